// ===== rtl/core/pcpd_pkg.sv =====
// Shared types and constants of the picture column post decoder.
// Used by the channel interfaces, the post parser and the top level.
package pcpd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int BYTE_W        = 8;
   localparam int ROW_W         = 9;
   localparam int HEIGHT_W      = 10;
   localparam int COLUMN_W      = 16;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(128);
   localparam logic [BYTE_W-1:0]   END_MARK     = 8'hFF;

   // Command codes of an input word.
   localparam logic CMD_TABLE_WRITE = 1'b0;
   localparam logic CMD_COLUMN_BYTE = 1'b1;

   // What the parser makes of one column byte.
   typedef struct packed {
      logic                emit;
      logic                pixel_valid;
      logic [ROW_W-1:0]    pixel_row;
      logic [COLUMN_W-1:0] column_number;
      logic                column_end;
   } parse_result_type;

endpackage

// ===== rtl/core/pcpd_req_if.sv =====
// Input channel of the picture column post decoder: valid/ready plus one word.
// Depends on pcpd_pkg for the field widths.
interface pcpd_req_if
   import pcpd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] table_index;
   logic [BYTE_W-1:0] table_value;
   logic [BYTE_W-1:0] column_byte;

   modport source (output valid, command, table_index, table_value, column_byte,
                   input ready);
   modport sink   (input valid, command, table_index, table_value, column_byte,
                   output ready);
endinterface

// ===== rtl/core/pcpd_rsp_if.sv =====
// Result channel of the picture column post decoder: valid/ready plus one word.
// Depends on pcpd_pkg for the field widths.
interface pcpd_rsp_if
   import pcpd_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                pixel_valid;
   logic [ROW_W-1:0]    pixel_row;
   logic [COLUMN_W-1:0] column_number;
   logic [BYTE_W-1:0]   color_index;
   logic                column_end;

   modport source (output valid, pixel_valid, pixel_row, column_number, color_index,
                   column_end, input ready);
   modport sink   (input valid, pixel_valid, pixel_row, column_number, color_index,
                   column_end, output ready);
endinterface

// ===== rtl/core/pcpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pcpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/core/pcpd_parser.sv =====
// Post stream parser: tracks the post phase, top row, length and column count.
// Depends on pcpd_pkg for widths, the end mark and the result struct.
module pcpd_parser
   import pcpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [BYTE_W-1:0]    column_byte,
   input  logic [HEIGHT_W-1:0]  column_height,
   output parse_result_type     result
);

   typedef enum logic [2:0] {
      PH_TOP  = 3'd0,
      PH_LEN  = 3'd1,
      PH_PAD  = 3'd2,
      PH_PIX  = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   top_ff, top_in;
   logic [BYTE_W-1:0]   remaining_ff, remaining_in;
   logic [BYTE_W-1:0]   offset_ff, offset_in;
   logic [COLUMN_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0]    row;

   assign row = ROW_W'(top_ff) + ROW_W'(offset_ff);

   always_comb begin
      phase_in     = phase_ff;
      top_in       = top_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      column_in    = column_ff;
      result       = '0;
      result.column_number = column_ff;
      unique case (phase_ff)
         PH_LEN: begin
            remaining_in = column_byte;
            offset_in    = '0;
            phase_in     = PH_PAD;
         end
         PH_PAD: begin
            phase_in = (remaining_ff == '0) ? PH_TAIL : PH_PIX;
         end
         PH_PIX: begin
            offset_in    = offset_ff + 1'b1;
            remaining_in = remaining_ff - 1'b1;
            if (remaining_in == '0) begin
               phase_in = PH_TAIL;
            end
            if (HEIGHT_W'(row) < column_height) begin
               result.emit        = 1'b1;
               result.pixel_valid = 1'b1;
               result.pixel_row   = row;
            end
         end
         PH_TAIL: begin
            phase_in = PH_TOP;
         end
         default: begin
            // Expecting a top row byte; unused codes fall back here too.
            phase_in = PH_TOP;
            if (column_byte == END_MARK) begin
               result.emit       = 1'b1;
               result.column_end = 1'b1;
               column_in         = column_ff + 1'b1;
            end else begin
               top_in   = column_byte;
               phase_in = PH_LEN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOP;
         top_ff       <= '0;
         remaining_ff <= '0;
         offset_ff    <= '0;
         column_ff    <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         top_ff       <= top_in;
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
         column_ff    <= column_in;
      end
   end

endmodule

// ===== rtl/core/picture_column_post_decoder.sv =====
// Top level of the picture column post decoder.
// Depends on pcpd_pkg, pcpd_req_if, pcpd_rsp_if, pcpd_ram and pcpd_parser.
//
// Usage: the req channel carries one word per transfer. A word with command
// set to the table-write code loads one light table entry and gives no result.
// A word with the column-byte code feeds the next byte of a picture column's
// post stream (top row, length, pad, pixel bytes, pad; a top row of 255 ends
// the column). Each drawn pixel and each column end produces one word on the
// rsp channel; header bytes, pad bytes, table writes and pixels at rows at or
// beyond the height register produce nothing.
// The csr port writes the column height register; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A result word passes from acceptance through stage one (the parse and the
// registered light table read) and then the output register before it is
// offered. A new word is accepted in every cycle while the receiver takes results;
// the light table memory's single read port and the parse of one byte per cycle set that rate.
// When the receiver stalls, the output register holds its word and the stage
// before it absorbs one more result; only when both are full does req.ready
// drop. Reset clears the parse state, the column counter, the pipeline valid
// bits and sets the height to 128. The light table is not cleared; entries
// must be written before a pixel refers to them.
module picture_column_post_decoder
   import pcpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   pcpd_req_if.sink            req_ch,
   pcpd_rsp_if.source          rsp_ch,
   input  logic                csr_write_en,
   input  logic [HEIGHT_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);

   logic [HEIGHT_W-1:0] height_ff;
   logic                accept;
   logic                byte_accept;
   logic                table_write;
   parse_result_type    parsed;

   // Stage one: parse result waiting for the table read data.
   logic                s1_valid_ff;
   parse_result_type    s1_ff;
   logic                s1_move;

   // Output register.
   logic                out_valid_ff;
   logic                out_pixel_valid_ff;
   logic [ROW_W-1:0]    out_row_ff;
   logic [COLUMN_W-1:0] out_column_ff;
   logic [BYTE_W-1:0]   out_color_ff;
   logic                out_end_ff;

   logic [BYTE_W-1:0]   table_data;

   assign s1_move      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign accept       = req_ch.valid && req_ch.ready;
   assign byte_accept  = accept && (req_ch.command == CMD_COLUMN_BYTE);
   assign table_write  = accept && (req_ch.command == CMD_TABLE_WRITE);

   // Height register.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         height_ff <= csr_write_data;
      end
   end

   pcpd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .advance       (byte_accept),
      .column_byte   (req_ch.column_byte),
      .column_height (height_ff),
      .result        (parsed)
   );

   // The table read is issued on every accepted column byte, so its data
   // lines up with stage one and stays put while stage one is held.
   pcpd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_light_table (
      .clock      (clock),
      .write_en   (table_write),
      .write_addr (req_ch.table_index[ADDR_W-1:0]),
      .write_data (req_ch.table_value),
      .read_en    (byte_accept),
      .read_addr  (req_ch.column_byte[ADDR_W-1:0]),
      .read_data  (table_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (byte_accept && parsed.emit) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (byte_accept && parsed.emit) begin
         s1_ff <= parsed;
      end
      if (s1_move) begin
         out_pixel_valid_ff <= s1_ff.pixel_valid;
         out_row_ff         <= s1_ff.pixel_row;
         out_column_ff      <= s1_ff.column_number;
         out_color_ff       <= s1_ff.column_end ? '0 : table_data;
         out_end_ff         <= s1_ff.column_end;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.pixel_valid   = out_pixel_valid_ff;
   assign rsp_ch.pixel_row     = out_row_ff;
   assign rsp_ch.column_number = out_column_ff;
   assign rsp_ch.color_index   = out_color_ff;
   assign rsp_ch.column_end    = out_end_ff;

   // A column end never carries a pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.column_end |-> !rsp_ch.pixel_valid && rsp_ch.pixel_row == '0)
      else $error("column end result carries a pixel");

   // Every drawn pixel lies inside the configured height.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.pixel_valid |-> HEIGHT_W'(rsp_ch.pixel_row) < height_ff)
      else $error("pixel row at or beyond column height");

   // Stage one fills only from an accepted column byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(byte_accept))
      else $error("stage one filled without an accepted byte");

   // A free output register always takes the waiting stage-one word.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("stage one word not moved to a free output register");

endmodule
